[rtl/core/dofl_pkg.sv]
// shared types and constants for the depth-of-field limits unit
package dofl_pkg;

   localparam int unsigned FL_W  = 14;
   localparam int unsigned FN_W  = 10;
   localparam int unsigned S_W   = 20;
   localparam int unsigned COC_W = 12;
   localparam int unsigned A_W   = 42;
   localparam int unsigned P_W   = 36;
   localparam int unsigned D_W   = 26;
   localparam int unsigned N_W   = 62;
   localparam int unsigned DEN_W = 48;
   localparam int unsigned Q_W   = 32;

   localparam logic [13:0] MM_SCALE = 14'd16000;
   localparam logic [Q_W-1:0] SAT_MAX = '1;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_DEGEN     = 2'd1,
      ST_NO_SUBJ   = 2'd2
   } status_type;

   typedef struct packed {
      logic [A_W:0]   hnum;   // a + p
      logic [N_W-1:0] num;    // s * a
      logic [D_W-1:0] d;
      logic [DEN_W-1:0] den_near;
      logic [DEN_W-1:0] den_far;
      logic           near_ok;
      logic           far_ok;
      status_type     status;
   } prep_type;

   typedef struct packed {
      logic [Q_W-1:0] hyper;
      logic [Q_W-1:0] near_lim;
      logic [Q_W-1:0] far_lim;
      logic           far_inf;
      status_type     status;
   } result_type;

endpackage

[rtl/core/depth_of_field_limits_unit.sv]
// depth-of-field limits unit: hyperfocal distance, near and far limits
// pipeline: 3 product stages, 62 divider stages and 1 output register
// throughput: one word per cycle while the output is not stalled, three dividers run in parallel pipelines
// a stall freezes the whole pipeline; the output register holds its word
// reset clears valid bits and sets the coc register to 461
module depth_of_field_limits_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // focal_length[13:0], f_number[23:14], focus_distance[43:24]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [103:0] rsp_tdata,   // hyperfocal[31:0], near[63:32], far[95:64], far_inf[96], status[98:97]
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [11:0]  csr_data
);
   localparam int unsigned DIV_LAT = dofl_pkg::N_W;
   logic [dofl_pkg::COC_W-1:0] coc_ff;
   logic adv, fv;
   dofl_pkg::prep_type prep;
   logic [dofl_pkg::Q_W-1:0] hq, nq, fq;
   logic [DIV_LAT-1:0] v_ff;
   dofl_pkg::prep_type meta_ff [DIV_LAT];
   logic out_v_ff;
   dofl_pkg::result_type res_ff, res_in;
   dofl_pkg::prep_type mt;

   assign adv        = !out_v_ff || rsp_tready;
   assign req_tready = adv;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) coc_ff <= 12'd461;
      else if (csr_valid) coc_ff <= csr_data;
   end

   dofl_front u_front (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_tvalid),
      .fl(req_tdata[13:0]), .fn(req_tdata[23:14]), .s(req_tdata[43:24]),
      .coc(coc_ff), .out_valid(fv), .prep(prep)
   );

   dofl_div #(.NW(dofl_pkg::N_W), .DW(dofl_pkg::DEN_W), .QW(dofl_pkg::Q_W)) u_hdiv (
      .clock(clock), .adv(adv),
      .num({19'd0, prep.hnum}),
      .den({22'd0, prep.d}), .quo(hq)
   );
   dofl_div #(.NW(dofl_pkg::N_W), .DW(dofl_pkg::DEN_W), .QW(dofl_pkg::Q_W)) u_ndiv (
      .clock(clock), .adv(adv), .num(prep.num),
      .den(prep.near_ok ? prep.den_near : dofl_pkg::DEN_W'(1)), .quo(nq)
   );
   dofl_div #(.NW(dofl_pkg::N_W), .DW(dofl_pkg::DEN_W), .QW(dofl_pkg::Q_W)) u_fdiv (
      .clock(clock), .adv(adv), .num(prep.num),
      .den(prep.far_ok ? prep.den_far : dofl_pkg::DEN_W'(1)), .quo(fq)
   );

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[DIV_LAT-2:0], fv};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         meta_ff[0] <= prep;
         for (int i = 1; i < DIV_LAT; i++) meta_ff[i] <= meta_ff[i-1];
      end
   end

   always_comb begin
      mt = meta_ff[DIV_LAT-1];
      res_in = '0;
      res_in.status = mt.status;
      case (mt.status)
         dofl_pkg::ST_OK: begin
            res_in.hyper    = hq;
            res_in.near_lim = mt.near_ok ? nq : '0;
            res_in.far_lim  = mt.far_ok ? fq : '0;
            res_in.far_inf  = !mt.far_ok;
         end
         dofl_pkg::ST_NO_SUBJ: res_in.hyper = hq;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= v_ff[DIV_LAT-1];
   end
   always_ff @(posedge clock) begin
      if (adv) res_ff <= res_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {5'd0, res_ff.status, res_ff.far_inf, res_ff.far_lim,
                        res_ff.near_lim, res_ff.hyper};

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("stall");
   a_inf_far: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res_ff.far_inf |-> res_ff.far_lim == '0) else $error("far");
   a_degen: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && res_ff.status == dofl_pkg::ST_DEGEN |-> res_ff.hyper == '0)
      else $error("degen");
endmodule

[rtl/core/dofl_front.sv]
// products and divisors, three register stages
module dofl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         adv,
   input  logic                         in_valid,
   input  logic [dofl_pkg::FL_W-1:0]    fl,
   input  logic [dofl_pkg::FN_W-1:0]    fn,
   input  logic [dofl_pkg::S_W-1:0]     s,
   input  logic [dofl_pkg::COC_W-1:0]   coc,
   output logic                         out_valid,
   output dofl_pkg::prep_type           prep
);
   // stage 1
   logic v1_ff;
   logic [27:0] fl2_ff;
   logic [21:0] fnc_ff;
   logic [dofl_pkg::FL_W-1:0] fl1_ff;
   logic [dofl_pkg::S_W-1:0] s1_ff;
   logic degen1_ff;
   // stage 2
   logic v2_ff;
   logic [dofl_pkg::A_W-1:0] a2_ff;
   logic [dofl_pkg::P_W-1:0] p2_ff;
   logic [dofl_pkg::D_W-1:0] d2_ff;
   logic [dofl_pkg::S_W-1:0] s2_ff;
   logic degen2_ff;
   // stage 3
   logic v3_ff;
   dofl_pkg::prep_type prep_ff;
   dofl_pkg::prep_type prep_in;
   logic [45:0] sd;
   logic [dofl_pkg::DEN_W-1:0] dn, df;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_comb begin
      sd = {26'd0, s2_ff} * {20'd0, d2_ff};
      dn = {6'd0, a2_ff} - {12'd0, p2_ff} + {2'd0, sd};
      df = {6'd0, a2_ff} + {12'd0, p2_ff} - {2'd0, sd};
      prep_in.hnum     = {1'b0, a2_ff} + {7'd0, p2_ff};
      prep_in.num      = {20'd0, a2_ff} * {42'd0, s2_ff};
      prep_in.d        = d2_ff;
      prep_in.den_near = dn;
      prep_in.den_far  = df;
      prep_in.near_ok  = !dn[dofl_pkg::DEN_W-1] && (dn != '0);
      prep_in.far_ok   = !df[dofl_pkg::DEN_W-1] && (df != '0);
      if (degen2_ff) begin
         prep_in.status = dofl_pkg::ST_DEGEN;
      end else if (s2_ff == '0) begin
         prep_in.status = dofl_pkg::ST_NO_SUBJ;
      end else begin
         prep_in.status = dofl_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         fl2_ff    <= {14'd0, fl} * {14'd0, fl};
         fnc_ff    <= {12'd0, fn} * {10'd0, coc};
         fl1_ff    <= fl;
         s1_ff     <= s;
         degen1_ff <= (fl == '0) || (fn == '0) || (coc == '0);
         a2_ff     <= {14'd0, fl2_ff} * {28'd0, dofl_pkg::MM_SCALE};
         p2_ff     <= {14'd0, fnc_ff} * {22'd0, fl1_ff};
         d2_ff     <= {fnc_ff, 4'd0};
         s2_ff     <= s1_ff;
         degen2_ff <= degen1_ff;
         prep_ff   <= prep_in;
      end
   end

   assign out_valid = v3_ff;
   assign prep      = prep_ff;
endmodule

[rtl/core/dofl_div.sv]
// pipelined restoring divider, one quotient bit per stage, saturating
module dofl_div #(
   parameter int unsigned NW = 62,
   parameter int unsigned DW = 48,
   parameter int unsigned QW = 32
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic [QW-1:0] quo
);
   // quotient bits above QW-1 only detect saturation
   localparam int unsigned ST = NW;

   for (genvar i = 0; i < ST; i++) begin : g_st
      localparam int unsigned B = NW - 1 - i;
      logic [NW-1:0] rem_src, q_src;
      logic [DW-1:0] den_src;
      logic [NW+DW-1:0] rem_w, dsh;
      logic ge;
      logic [NW-1:0] rem_ff, q_ff;
      logic [DW-1:0] den_ff;

      if (i == 0) begin : g_head
         assign rem_src = num;
         assign den_src = den;
         assign q_src   = '0;
      end else begin : g_tail
         assign rem_src = g_st[i-1].rem_ff;
         assign den_src = g_st[i-1].den_ff;
         assign q_src   = g_st[i-1].q_ff;
      end

      always_comb begin
         rem_w = {{DW{1'b0}}, rem_src};
         dsh   = {{NW{1'b0}}, den_src} << B;
         ge    = rem_w >= dsh;
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff <= ge ? NW'(rem_w - dsh) : rem_src;
            den_ff <= den_src;
            q_ff   <= q_src | (NW'(ge) << B);
         end
      end
   end

   assign quo = (g_st[ST-1].q_ff[NW-1:QW] != '0) ? '1 : g_st[ST-1].q_ff[QW-1:0];
endmodule
